// ----- rtl/driven_sine_oscillator_top_macros.svh -----
// ----------------------------------------------------------------------------
// driven sine oscillator assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef DRIVEN_SINE_OSCILLATOR_TOP_MACROS_SVH
`define DRIVEN_SINE_OSCILLATOR_TOP_MACROS_SVH

// pre holds at one edge, post must hold at the next
`define DSO_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// pre and post at the same edge
`define DSO_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

`endif

// ----- rtl/dso_pkg.sv -----
// ----------------------------------------------------------------------------
// dso_pkg
// Constants, types and the quarter-wave sine table of the oscillator.
// ----------------------------------------------------------------------------
package dso_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int MAX_BLOCK       = 4096;

  localparam int GAIN_W   = 16;
  localparam int PHASE_W  = 32;
  localparam int DRIVE_W  = 16;
  localparam int IDX_W    = 12;
  localparam int LEN_W    = 13;
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 17;
  localparam int PROD_W   = MAG_W + DRIVE_W;
  localparam int DIVD_W   = GAIN_W + LEN_W;
  localparam int QUO_W    = 16;

  localparam int SER_STEPS = 16;
  localparam int STEP_W    = $clog2(SER_STEPS);

  localparam int SINE_QTR_BITS = SINE_TABLE_BITS - 2;
  localparam int SINE_QTR      = 1 << SINE_QTR_BITS;
  localparam int SINE_SHIFT    = 18 - SINE_TABLE_BITS;

  localparam longint unsigned SIN_A = 102944;
  localparam longint unsigned SIN_B = 42047;
  localparam longint unsigned SIN_C = 4639;

  localparam int CLIP_POS = 32767;
  localparam int CLIP_NEG = 32768;
  localparam int DRIVE_SHIFT = 9;

  localparam logic [GAIN_W-1:0]  TARGET_GAIN_RESET = 16'd45875;
  localparam logic [DRIVE_W-1:0] DRIVE_RESET       = 16'd256;

  typedef enum logic [1:0] {
    REG_TARGET_GAIN  = 2'd0,
    REG_PHASE_STEP   = 2'd1,
    REG_DRIVE_FACTOR = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic              start;
    logic [MAG_W-1:0]  a;
    logic [QUO_W-1:0]  b;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [LEN_W-1:0]  divisor;
  } div_req_t;

  typedef logic [MAG_W-1:0] sine_tab_t [SINE_QTR];

  // magnitude of the polynomial sine at quadrant position j, Q16
  function automatic logic [MAG_W-1:0] sine_mag(input int unsigned j);
    longint unsigned z;
    longint unsigned z2;
    longint unsigned t;
    longint unsigned t2;
    z  = longint'(j) << SINE_SHIFT;
    z2 = (z * z) >> 16;
    t  = SIN_B - ((SIN_C * z2) >> 16);
    t2 = SIN_A - ((t * z2) >> 16);
    return MAG_W'((z * t2) >> 16);
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int j = 0; j < SINE_QTR; j++) begin
      tab[j] = sine_mag(j);
    end
    return tab;
  endfunction

  localparam sine_tab_t        SINE_TAB  = build_sine_tab();
  localparam logic [MAG_W-1:0] SINE_FULL = sine_mag(SINE_QTR);

endpackage

// ----- rtl/dso_mul.sv -----
// ----------------------------------------------------------------------------
// dso_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module dso_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dso_pkg::mul_req_t             req,
  output logic                          done,
  output logic [dso_pkg::PROD_W-1:0]    prod
);
  import dso_pkg::*;

  logic [MAG_W-1:0]  a_r;
  logic [PROD_W-1:0] p_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [MAG_W:0]    sum;

  // upper half accumulates, lower half shifts the multiplier out
  assign sum = {1'b0, p_r[PROD_W-1:QUO_W]} + (p_r[0] ? {1'b0, a_r} : {(MAG_W+1){1'b0}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(SER_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      p_r <= {{MAG_W{1'b0}}, req.b};
    end else if (busy_r) begin
      p_r <= {sum, p_r[QUO_W-1:1]};
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

// ----- rtl/dso_div.sv -----
// ----------------------------------------------------------------------------
// dso_div
// Restoring divider, one quotient bit per cycle, quotient known to fit 16 bits.
// ----------------------------------------------------------------------------
module dso_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dso_pkg::div_req_t           req,
  output logic                        done,
  output logic [dso_pkg::QUO_W-1:0]   quo
);
  import dso_pkg::*;

  logic [LEN_W-1:0]  rem_r;
  logic [QUO_W-1:0]  q_r;
  logic [LEN_W-1:0]  d_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [LEN_W:0]    trial;
  logic [LEN_W:0]    diffv;
  logic              ge;

  assign trial = {rem_r, q_r[QUO_W-1]};
  assign ge    = trial >= {1'b0, d_r};
  assign diffv = trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(SER_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder starts as the dividend's upper part, which stays below the divisor
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend[DIVD_W-1:QUO_W];
      q_r   <= req.dividend[QUO_W-1:0];
      d_r   <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diffv[LEN_W-1:0] : trial[LEN_W-1:0];
      q_r   <= {q_r[QUO_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ----- rtl/driven_sine_oscillator_top.sv -----
// ----------------------------------------------------------------------------
// driven_sine_oscillator_top
// Phase-accumulator sine source with overdrive, clip and a per-block gain ramp.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) takes one item per sample: its position
// in the block and the block length. Each item yields one Q1.15 sample on the
// output channel (out_valid / out_stall).
// Configuration writes (target gain, phase step, drive factor) go through the
// cfg_ channel, which is always ready; they are meant for when the block idles.
// Writing the target gain moves the old target into the ramp start gain.
// One item is worked on at a time: table lookup, then a bit-serial drive
// multiply run beside the serial gain-delta multiply, a serial divide by
// the block length and a serial gain multiply. The output register then
// loads the result, and the next item can be taken in the cycle after that
// load, never before the last item's result is in the output register.
// A result waiting in the output register does not hold the next item off;
// only a second finished result waits until the receiver drops out_stall.
// Reset clears the phase and the ramp start gain and loads the register
// defaults; no item is lost or repeated under any stall pattern.
// ----------------------------------------------------------------------------
module driven_sine_oscillator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        in_sample_index,
  input  logic [12:0]        in_block_length,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import dso_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOOK = 6'b000010,
    ST_MUL1 = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_MUL2 = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [GAIN_W-1:0]   tg_r, pg_r;
  logic [PHASE_W-1:0]  step_r, phase_r;
  logic [DRIVE_W-1:0]  drive_r;

  logic [LEN_W-1:0]    len_r, i_r;
  logic [GAIN_W-1:0]   diff_r;
  logic                up_r, last_r, neg_r;
  logic [SAMPLE_W-1:0] cmag_r, res_r, out_data_r;
  logic                out_valid_r;

  logic                in_acc;
  logic [LEN_W-1:0]    len_nz, len_cl, idx_ext, i_cl;
  logic                last_c, up_c;
  logic [GAIN_W-1:0]   diff_c;

  logic [SINE_TABLE_BITS-1:0] k;
  logic [1:0]                 quad;
  logic [SINE_QTR_BITS-1:0]   r;
  logic [SINE_QTR_BITS:0]     j;
  logic [MAG_W-1:0]           mag;

  logic [PROD_W-DRIVE_SHIFT-1:0] m;
  logic                          m_over;
  logic [SAMPLE_W-1:0]           cmag_c, gmag, res_c;
  logic [GAIN_W-1:0]             g;

  mul_req_t            mul_a_req, mul_b_req;
  div_req_t            div_req;
  logic                mul_a_done, mul_b_done, div_done;
  logic [PROD_W-1:0]   prod_a, prod_b;
  logic [QUO_W-1:0]    quo;
  logic                out_load;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // effective length, clamped index, last-sample flag, ramp up/down, gain delta
  always_comb begin
    len_nz  = (in_block_length == '0) ? LEN_W'(1) : in_block_length;
    len_cl  = (len_nz > LEN_W'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK) : len_nz;
    idx_ext = {1'b0, in_sample_index};
    i_cl    = (idx_ext > len_cl) ? len_cl : idx_ext;
    last_c  = (idx_ext + 1'b1) >= len_cl;
    up_c    = tg_r >= pg_r;
    diff_c  = up_c ? (tg_r - pg_r) : (pg_r - tg_r);
  end

  // quarter-wave lookup, mirrored in the second and fourth quadrants
  always_comb begin
    k    = phase_r[PHASE_W-1 -: SINE_TABLE_BITS];
    quad = k[SINE_TABLE_BITS-1 -: 2];
    r    = k[SINE_QTR_BITS-1:0];
    j    = quad[0] ? ((SINE_QTR_BITS+1)'(SINE_QTR) - {1'b0, r}) : {1'b0, r};
    mag  = j[SINE_QTR_BITS] ? SINE_FULL : SINE_TAB[j[SINE_QTR_BITS-1:0]];
  end

  // drive, clip, ramp gain and sign
  always_comb begin
    m      = prod_a[PROD_W-1:DRIVE_SHIFT];
    m_over = neg_r ? (m > (PROD_W-DRIVE_SHIFT)'(CLIP_NEG))
                   : (m > (PROD_W-DRIVE_SHIFT)'(CLIP_POS));
    cmag_c = m_over ? (neg_r ? SAMPLE_W'(CLIP_NEG) : SAMPLE_W'(CLIP_POS))
                    : m[SAMPLE_W-1:0];
    g      = up_r ? (pg_r + quo) : (pg_r - quo);
    gmag   = prod_a[2*GAIN_W-1:GAIN_W];
    res_c  = neg_r ? (SAMPLE_W'(0) - gmag) : gmag;
  end

  always_comb begin
    mul_a_req.start = (state_r == ST_LOOK) || ((state_r == ST_DIV) && div_done);
    mul_a_req.a     = (state_r == ST_LOOK) ? mag : {1'b0, cmag_r};
    mul_a_req.b     = (state_r == ST_LOOK) ? drive_r : g;
    mul_b_req.start = (state_r == ST_LOOK);
    mul_b_req.a     = {1'b0, diff_r};
    mul_b_req.b     = {{(QUO_W-LEN_W){1'b0}}, i_r};
    div_req.start    = (state_r == ST_MUL1) && mul_a_done && mul_b_done;
    div_req.dividend = prod_b[DIVD_W-1:0];
    div_req.divisor  = len_r;
  end

  dso_mul u_mul_a (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_a_req),
    .done (mul_a_done),
    .prod (prod_a)
  );

  dso_mul u_mul_b (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_b_req),
    .done (mul_b_done),
    .prod (prod_b)
  );

  dso_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quo  (quo)
  );

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_LOOK;
      ST_LOOK: state_nxt = ST_MUL1;
      ST_MUL1: if (mul_a_done && mul_b_done) state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_MUL2;
      ST_MUL2: if (mul_a_done) state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      tg_r        <= TARGET_GAIN_RESET;
      pg_r        <= '0;
      step_r      <= '0;
      drive_r     <= DRIVE_RESET;
      phase_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        phase_r <= phase_r + step_r;
      end
      // ramp start follows the target once the last sample's gain is formed
      if ((state_r == ST_DIV) && div_done && last_r) begin
        pg_r <= tg_r;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_TARGET_GAIN: begin
            pg_r <= tg_r;
            tg_r <= cfg_data[GAIN_W-1:0];
          end
          REG_PHASE_STEP:   step_r  <= cfg_data;
          REG_DRIVE_FACTOR: drive_r <= cfg_data[DRIVE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      len_r  <= len_cl;
      i_r    <= i_cl;
      last_r <= last_c;
      up_r   <= up_c;
      diff_r <= diff_c;
    end
    if (state_r == ST_LOOK) begin
      neg_r <= quad[1];
    end
    if (div_req.start) begin
      cmag_r <= cmag_c;
    end
    if ((state_r == ST_MUL2) && mul_a_done) begin
      res_r <= res_c;
    end
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

endmodule

// ----- rtl/dso_checker.sv -----
// ----------------------------------------------------------------------------
// dso_checker
// Port-level checks on item sequencing of the oscillator, bound to the top.
// ----------------------------------------------------------------------------
`include "driven_sine_oscillator_top_macros.svh"

module dso_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_sample_out
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // one item in flight at a time
  `DSO_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall, "input taken while busy")

  // a result never appears straight after an item is taken
  `DSO_ASSERT_NEXT(a_no_instant_result, in_acc, !$rose(out_valid), "result too early")

  // finishing an item always leaves its result on the output
  `DSO_ASSERT_NOW(a_result_on_finish, $fell(in_stall), out_valid, "item finished without result")

  `DSO_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_sample_out), "stalled result changed")

endmodule

bind driven_sine_oscillator_top dso_checker u_dso_checker (.*);
